/* src/apr_pkg.sv */
`timescale 1ns / 1ps

package apr_pkg;

  localparam int IndexBits = 20;
  localparam int FracBits  = 30;
  localparam int AmpBits   = 32;
  localparam int ProdBits  = 2 * AmpBits;
  localparam int SumBits   = ProdBits + 1;
  localparam int PosBits   = 5;
  localparam int CfgIdxBits = 3;

  typedef logic [IndexBits-1:0]       idx_t;
  typedef logic signed [AmpBits-1:0]  amp_t;
  typedef logic signed [ProdBits-1:0] prod_t;
  typedef logic signed [SumBits-1:0]  sum_t;
  typedef logic [PosBits-1:0]         pos_t;

  typedef enum logic {
    KindImag = 1'b0,
    KindReal = 1'b1
  } rot_kind_e;

  typedef enum logic {
    ModeExplicit  = 1'b0,
    ModeGenerated = 1'b1
  } idx_mode_e;

  typedef enum logic [CfgIdxBits-1:0] {
    RegRotationKind = 3'd0,
    RegIndexMode    = 3'd1,
    RegCosCoeff     = 3'd2,
    RegPairXmask    = 3'd3,
    RegPairBit      = 3'd4,
    RegParityMask   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    idx_mode_e index_mode;
    idx_t      pair_xmask;
    pos_t      ins_pos;
    idx_t      parity_mask;
  } idx_cfg_t;

  typedef struct packed {
    idx_t left;
    idx_t right;
    logic flip;
  } idx_res_t;

endpackage

/* src/apr_index_gen.sv */
`timescale 1ns / 1ps

module apr_index_gen (
  input  apr_pkg::idx_cfg_t cfg_i,
  input  apr_pkg::idx_t     left_index_i,
  input  apr_pkg::idx_t     right_index_i,
  output apr_pkg::idx_res_t res_o
);
  import apr_pkg::*;

  idx_t keep_mask;
  idx_t inserted;
  idx_t left;

  always_comb begin
    keep_mask = (idx_t'(1) << cfg_i.ins_pos) - idx_t'(1);
    inserted  = (left_index_i & keep_mask) | ((left_index_i & ~keep_mask) << 1);
    unique case (cfg_i.index_mode)
      ModeGenerated: begin
        left        = inserted;
        res_o.right = inserted ^ cfg_i.pair_xmask;
      end
      default: begin
        left        = left_index_i;
        res_o.right = right_index_i;
      end
    endcase
    res_o.left = left;
    res_o.flip = ^(left & cfg_i.parity_mask);
  end

endmodule

/* src/apr_mix.sv */
`timescale 1ns / 1ps

module apr_mix (
  input  apr_pkg::prod_t prod_a_i,
  input  apr_pkg::prod_t prod_b_i,
  input  logic           sub_i,
  output apr_pkg::amp_t  res_o
);
  import apr_pkg::*;

  localparam sum_t RoundHalf = sum_t'(1) <<< (FracBits - 1);
  localparam amp_t AmpMax    = {1'b0, {(AmpBits-1){1'b1}}};
  localparam amp_t AmpMin    = {1'b1, {(AmpBits-1){1'b0}}};

  sum_t a_ext;
  sum_t b_ext;
  sum_t sum;
  logic [SumBits-FracBits-AmpBits:0] upper;

  always_comb begin
    a_ext = sum_t'(prod_a_i);
    b_ext = sum_t'(prod_b_i);
    sum   = a_ext + (sub_i ? -b_ext : b_ext) + RoundHalf;
    upper = sum[SumBits-1:FracBits+AmpBits-1];
    if ((&upper) || !(|upper)) begin
      res_o = sum[FracBits+AmpBits-1:FracBits];
    end else if (sum[SumBits-1]) begin
      res_o = AmpMin;
    end else begin
      res_o = AmpMax;
    end
  end

endmodule

/* src/amplitude_pair_rotation_unit.sv */
`timescale 1ns / 1ps
// Rotates one pair of complex Q1.30 amplitudes per input word.
// Channels: s_axis carries the indices, sine coefficient and four amplitude
// parts, with tlast marking the last word of a batch. m_axis returns the four
// rotated parts and the two write-back indices, tlast copied through.
// The cfg channel writes one register per handshake (index 0 rotation kind,
// 1 index mode, 2 cosine, 3 xor mask, 4 insert bit, 5 parity mask); it is
// always ready and should only be written while the block is empty.
// A word moves through the input register, the product register (eight
// 32x32 multipliers) and the result register (add, round, saturate), whose
// valid is m_axis_tvalid. Throughput is one word per cycle while m_axis_tready is high.
// Reset empties all three stages and loads the register defaults.
// When m_axis_tready is low, words stall in place; each stage keeps taking
// words until it is full, so s_axis_tready drops only after all three
// stages hold a word.
module amplitude_pair_rotation_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // left_index, right_index, sin_coeff, re_left, im_left, re_right, im_right
  input  logic [199:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // new_re_left, new_im_left, new_re_right, new_im_right, left_basis, right_basis
  output logic [167:0] m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [apr_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [31:0]  cfg_data_i
);
  import apr_pkg::*;

  // configuration
  rot_kind_e rotation_kind_q;
  idx_mode_e index_mode_q;
  amp_t      cos_coeff_q;
  idx_t      pair_xmask_q;
  pos_t      ins_pos_q;
  idx_t      parity_mask_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotation_kind_q <= KindImag;
      index_mode_q    <= ModeExplicit;
      cos_coeff_q     <= amp_t'(32'h4000_0000);
      pair_xmask_q    <= idx_t'(1);
      ins_pos_q       <= '0;
      parity_mask_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegRotationKind: rotation_kind_q <= rot_kind_e'(cfg_data_i[0]);
        RegIndexMode:    index_mode_q    <= idx_mode_e'(cfg_data_i[0]);
        RegCosCoeff:     cos_coeff_q     <= cfg_data_i;
        RegPairXmask:    pair_xmask_q    <= cfg_data_i[IndexBits-1:0];
        RegPairBit:      ins_pos_q       <= cfg_data_i[PosBits-1:0];
        RegParityMask:   parity_mask_q   <= cfg_data_i[IndexBits-1:0];
        default: ;
      endcase
    end
  end

  // flow control
  logic a_valid_q, b_valid_q, c_valid_q;
  logic a_ready, b_ready, c_ready;

  assign c_ready       = !c_valid_q || m_axis_tready;
  assign b_ready       = !b_valid_q || c_ready;
  assign a_ready       = !a_valid_q || b_ready;
  assign s_axis_tready = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= s_axis_tvalid;
      if (b_ready) b_valid_q <= a_valid_q;
      if (c_ready) c_valid_q <= b_valid_q;
    end
  end

  // stage A: input register
  idx_t a_left_q, a_right_q;
  amp_t a_sin_q, a_rl_q, a_il_q, a_rr_q, a_ir_q;
  logic a_last_q;

  always_ff @(posedge clk_i) begin
    if (a_ready && s_axis_tvalid) begin
      a_left_q  <= s_axis_tdata[19:0];
      a_right_q <= s_axis_tdata[39:20];
      a_sin_q   <= s_axis_tdata[71:40];
      a_rl_q    <= s_axis_tdata[103:72];
      a_il_q    <= s_axis_tdata[135:104];
      a_rr_q    <= s_axis_tdata[167:136];
      a_ir_q    <= s_axis_tdata[199:168];
      a_last_q  <= s_axis_tlast;
    end
  end

  idx_cfg_t idx_cfg;
  idx_res_t idx_res;

  assign idx_cfg.index_mode  = index_mode_q;
  assign idx_cfg.pair_xmask  = pair_xmask_q;
  assign idx_cfg.ins_pos     = ins_pos_q;
  assign idx_cfg.parity_mask = parity_mask_q;

  apr_index_gen u_index_gen (
    .cfg_i         (idx_cfg),
    .left_index_i  (a_left_q),
    .right_index_i (a_right_q),
    .res_o         (idx_res)
  );

  amp_t  partner [4];
  logic  sub_d   [4];
  prod_t cprod_d [4];
  prod_t qprod_d [4];
  amp_t  own     [4];

  assign own[0] = a_rl_q;
  assign own[1] = a_il_q;
  assign own[2] = a_rr_q;
  assign own[3] = a_ir_q;

  always_comb begin
    unique case (rotation_kind_q)
      KindReal: begin
        partner[0] = a_rr_q;
        partner[1] = a_ir_q;
        partner[2] = a_rl_q;
        partner[3] = a_il_q;
        sub_d[0]   = !idx_res.flip;
        sub_d[1]   = !idx_res.flip;
        sub_d[2]   = idx_res.flip;
        sub_d[3]   = idx_res.flip;
      end
      default: begin
        partner[0] = a_ir_q;
        partner[1] = a_rr_q;
        partner[2] = a_il_q;
        partner[3] = a_rl_q;
        sub_d[0]   = 1'b1;
        sub_d[1]   = 1'b0;
        sub_d[2]   = 1'b1;
        sub_d[3]   = 1'b0;
      end
    endcase
  end

  for (genvar g = 0; g < 4; g++) begin : g_mul
    assign cprod_d[g] = cos_coeff_q * own[g];
    assign qprod_d[g] = a_sin_q * partner[g];
  end

  // stage B: product register
  prod_t b_cprod_q [4];
  prod_t b_qprod_q [4];
  logic  b_sub_q   [4];
  idx_t  b_left_q, b_right_q;
  logic  b_last_q;

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_cprod_q <= cprod_d;
      b_qprod_q <= qprod_d;
      b_sub_q   <= sub_d;
      b_left_q  <= idx_res.left;
      b_right_q <= idx_res.right;
      b_last_q  <= a_last_q;
    end
  end

  amp_t mix_d [4];

  for (genvar g = 0; g < 4; g++) begin : g_mix
    apr_mix u_mix (
      .prod_a_i (b_cprod_q[g]),
      .prod_b_i (b_qprod_q[g]),
      .sub_i    (b_sub_q[g]),
      .res_o    (mix_d[g])
    );
  end

  // stage C: result register
  amp_t c_amp_q [4];
  idx_t c_left_q, c_right_q;
  logic c_last_q;

  always_ff @(posedge clk_i) begin
    if (c_ready && b_valid_q) begin
      c_amp_q   <= mix_d;
      c_left_q  <= b_left_q;
      c_right_q <= b_right_q;
      c_last_q  <= b_last_q;
    end
  end

  assign m_axis_tvalid = c_valid_q;
  assign m_axis_tdata  = {c_right_q, c_left_q, c_amp_q[3], c_amp_q[2], c_amp_q[1], c_amp_q[0]};
  assign m_axis_tlast  = c_last_q;

endmodule
